// ===== sv/ofr_pkg.sv =====
// Shared constants, action codes and address helpers for the overlapped frame ring.
`default_nettype none

package ofr_pkg;

  localparam int FRAME_LEN   = 1024;
  localparam int CHANNELS    = 2;
  localparam int RING_FRAMES = 4;

  localparam int HALF_LEN  = FRAME_LEN / 2;
  localparam int MEM_DEPTH = RING_FRAMES * CHANNELS * FRAME_LEN;

  localparam int SAMPLE_W = 24;
  localparam int ADDR_W   = $clog2(MEM_DEPTH);
  localparam int FR_W     = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = $clog2(FRAME_LEN);
  localparam int HALF_W   = (HALF_LEN > 1) ? $clog2(HALF_LEN) : 1;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  typedef logic [FR_W-1:0]   frame_t;
  typedef logic [ADDR_W-1:0] addr_t;

  function automatic frame_t next_frame(input frame_t f);
    frame_t r;
    if (f == frame_t'(RING_FRAMES - 1)) begin
      r = '0;
    end else begin
      r = f + frame_t'(1);
    end
    return r;
  endfunction

  // Flat store address of one sample: frame, then channel, then position.
  function automatic addr_t addr_of(input frame_t f, input logic [CH_W-1:0] c,
                                    input logic [POS_W-1:0] i);
    return addr_t'(f) * addr_t'(CHANNELS * FRAME_LEN)
         + addr_t'(c) * addr_t'(FRAME_LEN)
         + addr_t'(i);
  endfunction

endpackage

`default_nettype wire

// ===== sv/overlapped_frame_ring.sv =====
// Half-overlap multichannel frame ring with a copy sequencer on its one write port.
`default_nettype none

// The ring holds RING_FRAMES frames of CHANNELS x FRAME_LEN samples in one
// memory with one write and one registered read port. Every item produces one
// result. A release, an unused action, a dropped push, and a read or release
// on an empty ring go straight to ST_DONE. Any other read passes through
// ST_READ for the registered read port. Any other push also passes through
// ST_PUSH1 unless there is a single channel, since each channel's sample
// takes one write on the shared port. A push that completes a frame then copies
// the upper half of every channel into the lower half of the next frame. The
// copy goes through that same port, one sample a cycle, in ST_COPY and ST_FLUSH.
// No clearing pass runs after reset. Every position of a completed frame has
// been written by a push or by a copy. The one exception is the lower half of
// frame 0 before the ring first wraps, and a flag makes it read as zero.
// The input stalls while an item is in progress; a finished result waits in
// the output register so the next item can start meanwhile.
module overlapped_frame_ring (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          action,
  input  wire logic signed [23:0]  sample_ch0,
  input  wire logic signed [23:0]  sample_ch1,
  input  wire logic [9:0]          element_index,
  input  wire logic                channel_select,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [23:0]       read_value,
  output logic                     ring_empty,
  output logic                     ring_full,
  output logic                     sample_dropped,
  output logic                     request_failed,
  output logic [1:0]               frames_ready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUSH1 = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int SW = ofr_pkg::SAMPLE_W;

  logic [2:0] state;

  logic [SW-1:0] mem [ofr_pkg::MEM_DEPTH];
  logic [SW-1:0] rdata;
  logic                  mem_we;
  ofr_pkg::addr_t        mem_waddr;
  logic [SW-1:0]         mem_wdata;
  ofr_pkg::addr_t        mem_raddr;

  ofr_pkg::frame_t           write_frame;
  ofr_pkg::frame_t           read_frame;
  logic [ofr_pkg::POS_W-1:0] fill_position;
  logic                      wrapped;

  logic [SW-1:0]              hold_ch1;
  logic                       zero_rd;
  logic [ofr_pkg::CH_W-1:0]   copy_ch;
  logic [ofr_pkg::HALF_W-1:0] copy_i;
  logic                       wpend;
  ofr_pkg::addr_t             wdst;

  logic signed [SW-1:0] res_value;
  logic                 res_dropped;
  logic                 res_failed;

  logic            accept;
  logic            completes;
  logic            is_empty;
  logic            is_full;
  logic            copy_last;
  logic            out_free;
  logic            idx_ok;
  logic            ch_ok;
  ofr_pkg::frame_t wf_next;
  ofr_pkg::frame_t pending;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign wf_next   = ofr_pkg::next_frame(write_frame);
  assign is_empty  = (read_frame == write_frame);
  assign is_full   = (read_frame == wf_next);
  assign completes = (fill_position == ofr_pkg::POS_W'(ofr_pkg::FRAME_LEN - 1));
  assign copy_last = (copy_ch == ofr_pkg::CH_W'(ofr_pkg::CHANNELS - 1))
                  && (copy_i == ofr_pkg::HALF_W'(ofr_pkg::HALF_LEN - 1));
  assign out_free  = !out_valid || !out_stall;
  assign idx_ok    = (32'(element_index) < ofr_pkg::FRAME_LEN);
  assign ch_ok     = (32'(channel_select) < ofr_pkg::CHANNELS);

  always_comb begin
    if (write_frame >= read_frame) begin
      pending = write_frame - read_frame;
    end else begin
      pending = ofr_pkg::frame_t'(32'(write_frame) + ofr_pkg::RING_FRAMES
                                  - 32'(read_frame));
    end
  end

  // Write and read port selection for the shared store.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ofr_pkg::addr_of(write_frame, '0, fill_position);
    mem_wdata = sample_ch0;
    mem_raddr = ofr_pkg::addr_of(read_frame, ofr_pkg::CH_W'(channel_select),
                                 ofr_pkg::POS_W'(element_index));
    case (state)
      ST_IDLE: begin
        mem_we = accept && (action == ofr_pkg::ACT_PUSH) && !(completes && is_full);
      end
      ST_PUSH1: begin
        mem_we    = 1'b1;
        mem_waddr = ofr_pkg::addr_of(write_frame, ofr_pkg::CH_W'(ofr_pkg::CHANNELS - 1),
                                     fill_position);
        mem_wdata = hold_ch1;
      end
      ST_COPY, ST_FLUSH: begin
        mem_we    = wpend;
        mem_waddr = wdst;
        mem_wdata = rdata;
        mem_raddr = ofr_pkg::addr_of(write_frame, copy_ch,
                      ofr_pkg::POS_W'(copy_i) + ofr_pkg::POS_W'(ofr_pkg::HALF_LEN));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_frame   <= '0;
      read_frame    <= '0;
      fill_position <= ofr_pkg::POS_W'(ofr_pkg::HALF_LEN);
      wrapped       <= 1'b0;
      wpend         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_value   <= '0;
            res_dropped <= 1'b0;
            res_failed  <= 1'b0;
            hold_ch1    <= sample_ch1;
            copy_ch     <= '0;
            copy_i      <= '0;
            wpend       <= 1'b0;
            state       <= ST_DONE;
            case (action)
              ofr_pkg::ACT_PUSH: begin
                if (completes && is_full) begin
                  res_dropped <= 1'b1;
                end else if (ofr_pkg::CHANNELS > 1) begin
                  state <= ST_PUSH1;
                end else if (completes) begin
                  state <= ST_COPY;
                end else begin
                  fill_position <= fill_position + ofr_pkg::POS_W'(1);
                end
              end
              ofr_pkg::ACT_READ: begin
                if (is_empty) begin
                  res_failed <= 1'b1;
                end else begin
                  // Frame 0's lower half is never written before the first wrap.
                  zero_rd <= !idx_ok || !ch_ok
                          || (read_frame == '0 && !wrapped
                              && 32'(element_index) < ofr_pkg::HALF_LEN);
                  state   <= ST_READ;
                end
              end
              ofr_pkg::ACT_RELEASE: begin
                if (is_empty) begin
                  res_failed <= 1'b1;
                end else begin
                  read_frame <= ofr_pkg::next_frame(read_frame);
                end
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_PUSH1: begin
          if (completes) begin
            state <= ST_COPY;
          end else begin
            fill_position <= fill_position + ofr_pkg::POS_W'(1);
            state         <= ST_DONE;
          end
        end
        ST_READ: begin
          res_value <= zero_rd ? '0 : rdata;
          state     <= ST_DONE;
        end
        ST_COPY: begin
          // The read issued now is written into the next frame in the cycle after.
          wpend <= 1'b1;
          wdst  <= ofr_pkg::addr_of(wf_next, copy_ch, ofr_pkg::POS_W'(copy_i));
          if (copy_last) begin
            state <= ST_FLUSH;
          end else if (copy_i == ofr_pkg::HALF_W'(ofr_pkg::HALF_LEN - 1)) begin
            copy_i  <= '0;
            copy_ch <= copy_ch + ofr_pkg::CH_W'(1);
          end else begin
            copy_i <= copy_i + ofr_pkg::HALF_W'(1);
          end
        end
        ST_FLUSH: begin
          wpend         <= 1'b0;
          write_frame   <= wf_next;
          fill_position <= ofr_pkg::POS_W'(ofr_pkg::HALF_LEN);
          if (wf_next == '0) begin
            wrapped <= 1'b1;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            read_value     <= res_value;
            sample_dropped <= res_dropped;
            request_failed <= res_failed;
            ring_empty     <= is_empty;
            ring_full      <= is_full;
            frames_ready   <= 2'(pending);
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
